FILE: src/ptts_pkg.sv
// Package for the periodic timer table scan: codes, widths and defaults.
package ptts_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 32;
	localparam int SLOT_W        = 4;
	localparam int LIMIT_W       = 16;
	localparam int OPC_W         = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_TIME = 2'd0,
		OP_ARM  = 2'd1,
		OP_STOP = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic {
		KIND_FIRE    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} scan_state_t;

endpackage

FILE: src/periodic_timer_table_scan.sv
// Timer slot table: arm/stop writes and a sequential scan over a slot memory.
// Arm and stop give no result.
// A time step scans one slot per cycle through the slot memory read port,
// except while a firing slot waits for room in a stalled output register;
// fire results come out during the scan, one per fired slot.
// One item at a time; the next item is accepted once the summary is registered.
// Reset clears the active bits and control state; slot memory is not cleared.
module periodic_timer_table_scan
	import ptts_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OPC_W-1:0]     opcode,
	input  logic [TIME_BITS-1:0] now,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [TIME_BITS-1:0] period,
	input  logic [TIME_BITS-1:0] begin_time,
	input  logic [LIMIT_W-1:0]   repeat_limit,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [SLOT_W-1:0]    fired_slot,
	output logic [TIME_BITS-1:0] wait_time,
	output logic                 last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
	localparam int TB    = TIME_BITS;

	// memory word layout: period | begin | last fire | limit | ticks
	localparam int TICK_LO = 0;
	localparam int LIM_LO  = LIMIT_W;
	localparam int LAST_LO = 2 * LIMIT_W;
	localparam int BEG_LO  = LAST_LO + TB;
	localparam int PER_LO  = BEG_LO + TB;
	localparam int MEM_W   = PER_LO + TB;

	localparam logic [TB-1:0] TIME_ALL_ONES = {TB{1'b1}};

	scan_state_t state_q, state_d;

	logic [NUM_SLOTS-1:0] active_q;
	logic [MEM_W-1:0]     mem [NUM_SLOTS];
	logic [MEM_W-1:0]     rdata_q;
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [MEM_W-1:0]     mem_wdata;

	logic [CNT_W-1:0]     rd_cnt_q;
	logic [TB-1:0]        now_q;
	logic                 s1_valid_q;
	logic [IDX_W-1:0]     s1_idx_q;
	logic                 s2_valid_q;
	logic [TB-1:0]        s2_cand_q;
	logic [TB-1:0]        best_q;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [SLOT_W-1:0]    fired_slot_q;
	logic [TB-1:0]        wait_time_q;
	logic                 last_q;

	logic                 in_acc, in_range, out_free;
	logic                 issue_rd, adv, scan_done;
	logic                 fire_push, sum_push;

	logic [TB-1:0]        r_period, r_begin, r_last;
	logic [LIMIT_W-1:0]   r_limit, r_ticks, ticks_inc;
	logic                 part, fire, auto_stop;
	logic [TB:0]          deadline, cand_wide;
	logic [TB-1:0]        cand;

	assign in_acc   = in_valid && !in_stall;
	assign in_range = CMP_W'(slot) < CMP_W'(NUM_SLOTS);
	assign out_free = !out_valid_q || !out_stall;

	// stage 1 evaluation of the slot just read
	assign r_period  = rdata_q[PER_LO +: TB];
	assign r_begin   = rdata_q[BEG_LO +: TB];
	assign r_last    = rdata_q[LAST_LO +: TB];
	assign r_limit   = rdata_q[LIM_LO +: LIMIT_W];
	assign r_ticks   = rdata_q[TICK_LO +: LIMIT_W];
	assign ticks_inc = r_ticks + LIMIT_W'(1);

	assign part      = active_q[s1_idx_q] && ((r_begin == '0) || (now_q >= r_begin));
	assign deadline  = {1'b0, r_last} + {1'b0, r_period};
	assign fire      = deadline <= {1'b0, now_q};
	assign auto_stop = (r_limit != '0) && (r_limit <= ticks_inc);
	assign cand_wide = fire ? {1'b0, r_period} : (deadline - {1'b0, now_q});
	assign cand      = cand_wide[TB] ? TIME_ALL_ONES : cand_wide[TB-1:0];

	// a firing slot waits for room in the output register
	assign adv       = !(s1_valid_q && part && fire && !out_free);
	assign issue_rd  = rd_cnt_q < CNT_W'(NUM_SLOTS);
	assign scan_done = !issue_rd && !s1_valid_q && !s2_valid_q;

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = IDX_W'(slot);
		mem_raddr = rd_cnt_q[IDX_W-1:0];
		mem_wdata = {period, begin_time, now, repeat_limit, LIMIT_W'(0)};
		fire_push = 1'b0;
		sum_push  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && in_range && (opcode == OP_ARM)) begin
					mem_we = 1'b1;
				end
				if (in_valid && (opcode == OP_TIME)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				mem_re = adv && issue_rd;
				if (adv && s1_valid_q && part && fire) begin
					fire_push = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = s1_idx_q;
					mem_wdata = {r_period, r_begin, now_q, r_limit,
						(r_limit != '0) ? ticks_inc : r_ticks};
				end
				if (scan_done && out_free) begin
					sum_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (state_q == ST_IDLE) begin
			if (in_valid && in_range && (opcode == OP_ARM)) begin
				active_q[IDX_W'(slot)] <= 1'b1;
			end else if (in_valid && in_range && (opcode == OP_STOP)) begin
				active_q[IDX_W'(slot)] <= 1'b0;
			end
		end else if (fire_push && auto_stop) begin
			active_q[s1_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q   <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			rd_cnt_q   <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= adv && s1_valid_q && part;
			if (adv) begin
				s1_valid_q <= issue_rd;
				if (issue_rd) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (opcode == OP_TIME)) begin
			now_q <= now;
		end
		if (adv) begin
			s1_idx_q  <= rd_cnt_q[IDX_W-1:0];
			s2_cand_q <= cand;
		end
		if (state_q == ST_IDLE) begin
			best_q <= TIME_ALL_ONES;
		end else if (s2_valid_q && (s2_cand_q < best_q)) begin
			best_q <= s2_cand_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_push || sum_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_push) begin
			kind_q       <= KIND_FIRE;
			fired_slot_q <= SLOT_W'(s1_idx_q);
			wait_time_q  <= '0;
			last_q       <= 1'b0;
		end else if (sum_push) begin
			kind_q       <= KIND_SUMMARY;
			fired_slot_q <= '0;
			wait_time_q  <= best_q;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign fired_slot = fired_slot_q;
	assign wait_time  = wait_time_q;
	assign last       = last_q;

`ifndef SYNTH
	// a fire transaction is never pushed over an unconsumed result
	a_fire_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire_push |-> out_free)
		else $error("fire pushed while output blocked");

	// the scan pipeline is empty whenever the block is idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!s1_valid_q && !s2_valid_q))
		else $error("scan stages busy while idle");

	// the read counter never runs past the table
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= CNT_W'(NUM_SLOTS))
		else $error("scan counter overrun");

	// a summary always closes the item, a fire never does
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == KIND_SUMMARY)))
		else $error("last flag disagrees with kind");
`endif

endmodule
